FILE: rtl/tor_pkg.sv
// Shared types and constants for the tilt orientation righting sequencer.
package tor_pkg;

	localparam logic [2:0] ORIENT_UPRIGHT     = 3'd0;
	localparam logic [2:0] ORIENT_UPSIDE_DOWN = 3'd1;
	localparam logic [2:0] ORIENT_LEFT        = 3'd2;
	localparam logic [2:0] ORIENT_RIGHT       = 3'd3;
	localparam logic [2:0] ORIENT_UNKNOWN     = 3'd4;

	localparam logic [1:0] CMD_NONE   = 2'd0;
	localparam logic [1:0] CMD_CLOSED = 2'd1;
	localparam logic [1:0] CMD_OPEN   = 2'd2;

	// Blind sequence phase ends, counted past the confirm time.
	localparam logic [16:0] BLIND_OPEN_TOP_MS  = 17'd2000;
	localparam logic [16:0] BLIND_OPEN_SIDE_MS = 17'd6000;
	localparam logic [16:0] BLIND_END_MS       = 17'd10000;

	localparam logic [14:0] TILT_THRESHOLD_RST = 15'd700;
	localparam logic [15:0] CONFIRM_MS_RST     = 16'd1000;
	localparam logic [15:0] SETTLE_MS_RST      = 16'd3000;

	localparam logic [1:0] REG_TILT_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_CONFIRM_MS     = 2'd1;
	localparam logic [1:0] REG_SETTLE_MS      = 2'd2;

	typedef struct packed {
		logic [31:0]        now_ms;
		logic signed [15:0] accel_y;
		logic signed [15:0] accel_z;
	} sample_t;

	typedef struct packed {
		logic [2:0] orientation;
		logic [1:0] top_panel_cmd;
		logic [1:0] side_panel_cmd;
		logic       righting_done;
	} result_t;

	typedef struct packed {
		logic [14:0] tilt_threshold;
		logic [15:0] confirm_ms;
		logic [15:0] settle_ms;
	} cfg_t;

endpackage

FILE: rtl/tilt_orientation_righting_sequencer_core.sv
// Top level of the tilt orientation righting sequencer.
//
// Usage: each sample word (now_ms, accel_y, accel_z) entering on the sample
// channel yields exactly one result word (orientation, panel commands and
// righting_done) on the result channel, in order. A word moves when valid
// is high and stall is low at a rising clock edge.
// Path: a sample accepted into the input register is classified from it, and its
// result is registered into the output register when that register is empty or
// its word moves; a stalled result holds the sample in the input register.
// Throughput: one word per cycle while the result channel is not stalled. The only
// loop is the held orientation and change stamp, updated in the same cycle the
// sample leaves the input register, so back-to-back samples see each other's state.
// Stall: when the result is stalled and the input register is full, the
// sample channel stalls; one sample can still be taken while a result waits.
// Reset: arst_n clears both registers' valid flags, the held orientation to
// upright, the change stamp to zero and the configuration registers to
// threshold 700, confirm 1000 ms and settle 3000 ms. Configuration is to be written
// over the APB port only while no word is in flight; the block does not enforce this.
module tilt_orientation_righting_sequencer_core
	import tor_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  sample_t     sample,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	cfg_t                 cfg;
	sample_t              smp_s1;
	logic                 vld_s1;
	result_t              res_s2;
	logic                 vld_s2;
	logic [2:0]           held_q;
	logic [TIME_BITS-1:0] stamp_q;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS+31:0] now_ext;
	logic [TIME_BITS-1:0] elapsed;
	logic [2:0]           cls;
	logic                 changed;
	logic                 adv;
	result_t              res_d;

	tor_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tor_classify u_classify (
		.accel_y     (smp_s1.accel_y),
		.accel_z     (smp_s1.accel_z),
		.threshold   (cfg.tilt_threshold),
		.orientation (cls)
	);

	// The timestamp is cut or zero-extended to the time width.
	assign now_ext = {{TIME_BITS{1'b0}}, smp_s1.now_ms};
	assign now_t   = now_ext[TIME_BITS-1:0];
	assign changed = (cls != held_q);
	assign elapsed = changed ? '0 : (now_t - stamp_q);

	tor_cmd #(
		.TIME_BITS (TIME_BITS)
	) u_cmd (
		.orientation    (cls),
		.elapsed        (elapsed),
		.confirm_ms     (cfg.confirm_ms),
		.settle_ms      (cfg.settle_ms),
		.top_panel_cmd  (res_d.top_panel_cmd),
		.side_panel_cmd (res_d.side_panel_cmd),
		.righting_done  (res_d.righting_done)
	);

	assign res_d.orientation = cls;

	assign adv          = vld_s1 && (!vld_s2 || !result_stall);
	assign sample_stall = vld_s1 && !adv;
	assign result_valid = vld_s2;
	assign result       = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (!sample_stall) begin
			vld_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!sample_stall && sample_valid) begin
			smp_s1 <= sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (!result_stall) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= ORIENT_UPRIGHT;
			stamp_q <= '0;
		end else if (adv) begin
			held_q <= cls;
			if (changed) begin
				stamp_q <= now_t;
			end
		end
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> vld_s1 && vld_s2 && result_stall)
		else $error("sample stalled while a stage could take it");

	a_held_tracks_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> held_q == $past(cls) && res_s2.orientation == held_q)
		else $error("held orientation differs from the last issued result");

	a_stamp_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		adv && changed |=> stamp_q == $past(now_t))
		else $error("change stamp not taken on a class change");

	a_done_classes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.righting_done |->
			result.orientation == ORIENT_UPRIGHT || result.orientation == ORIENT_UNKNOWN)
		else $error("done raised in a righting branch");

	a_change_clears_outputs: assert property (@(posedge clk) disable iff (!arst_n)
		adv && changed && cls != ORIENT_UPSIDE_DOWN |=>
			res_s2.top_panel_cmd == CMD_NONE && !res_s2.righting_done)
		else $error("commands issued at zero elapsed time");

endmodule

FILE: rtl/tor_regs.sv
// Configuration register file with its APB-style access port.
module tor_regs
	import tor_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tilt_threshold <= TILT_THRESHOLD_RST;
			cfg_q.confirm_ms     <= CONFIRM_MS_RST;
			cfg_q.settle_ms      <= SETTLE_MS_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_TILT_THRESHOLD: cfg_q.tilt_threshold <= pwdata[14:0];
				REG_CONFIRM_MS:     cfg_q.confirm_ms     <= pwdata[15:0];
				REG_SETTLE_MS:      cfg_q.settle_ms      <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_TILT_THRESHOLD: prdata = {17'd0, cfg_q.tilt_threshold};
			REG_CONFIRM_MS:     prdata = {16'd0, cfg_q.confirm_ms};
			REG_SETTLE_MS:      prdata = {16'd0, cfg_q.settle_ms};
			default:            prdata = 32'd0;
		endcase
	end

endmodule

FILE: rtl/tor_classify.sv
// Orientation classifier: compares the Y and Z counts against the tilt threshold.
module tor_classify
	import tor_pkg::*;
(
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic [14:0]        threshold,
	output logic [2:0]         orientation
);

	logic signed [16:0] y_x;
	logic signed [16:0] z_x;
	logic signed [16:0] t_pos;
	logic signed [16:0] t_neg;
	logic               y_level;
	logic               z_level;

	assign y_x   = {accel_y[15], accel_y};
	assign z_x   = {accel_z[15], accel_z};
	assign t_pos = $signed({2'b00, threshold});
	assign t_neg = -t_pos;

	assign y_level = (y_x > t_neg) && (y_x < t_pos);
	assign z_level = (z_x > t_neg) && (z_x < t_pos);

	always_comb begin
		if (z_x > t_pos && y_level) begin
			orientation = ORIENT_UPRIGHT;
		end else if (z_x < t_neg && y_level) begin
			orientation = ORIENT_UPSIDE_DOWN;
		end else if (y_x > t_pos && z_level) begin
			orientation = ORIENT_LEFT;
		end else if (y_x < t_neg && z_level) begin
			orientation = ORIENT_RIGHT;
		end else begin
			orientation = ORIENT_UNKNOWN;
		end
	end

endmodule

FILE: rtl/tor_cmd.sv
// Panel command and done logic driven by orientation and elapsed time.
module tor_cmd
	import tor_pkg::*;
#(
	parameter int TIME_BITS = 32
) (
	input  logic [2:0]           orientation,
	input  logic [TIME_BITS-1:0] elapsed,
	input  logic [15:0]          confirm_ms,
	input  logic [15:0]          settle_ms,
	output logic [1:0]           top_panel_cmd,
	output logic [1:0]           side_panel_cmd,
	output logic                 righting_done
);

	// Thresholds fit in 17 bits; compare everything at a common width.
	localparam int CW = (TIME_BITS > 17) ? TIME_BITS : 17;

	logic [CW-1:0] e_w;
	logic [CW-1:0] c_w;
	logic [CW-1:0] s_w;
	logic [CW-1:0] cs_w;
	logic [CW-1:0] c_top_w;
	logic [CW-1:0] c_side_w;
	logic [CW-1:0] c_end_w;

	assign e_w      = CW'(elapsed);
	assign c_w      = CW'(confirm_ms);
	assign s_w      = CW'(settle_ms);
	assign cs_w     = CW'({1'b0, confirm_ms} + {1'b0, settle_ms});
	assign c_top_w  = CW'({1'b0, confirm_ms} + BLIND_OPEN_TOP_MS);
	assign c_side_w = CW'({1'b0, confirm_ms} + BLIND_OPEN_SIDE_MS);
	assign c_end_w  = CW'({1'b0, confirm_ms} + BLIND_END_MS);

	always_comb begin
		top_panel_cmd  = CMD_NONE;
		side_panel_cmd = CMD_NONE;
		righting_done  = 1'b0;
		case (orientation)
			ORIENT_UPRIGHT: begin
				righting_done = (e_w > c_w);
			end
			ORIENT_UPSIDE_DOWN: begin
				side_panel_cmd = CMD_CLOSED;
				if (e_w > s_w) begin
					top_panel_cmd = CMD_OPEN;
				end
			end
			ORIENT_LEFT, ORIENT_RIGHT: begin
				// The longer delay is tested first so the open step is reachable.
				if (e_w > cs_w) begin
					top_panel_cmd  = CMD_CLOSED;
					side_panel_cmd = CMD_OPEN;
				end else if (e_w > c_w) begin
					top_panel_cmd = CMD_CLOSED;
				end
			end
			default: begin
				if (e_w > c_end_w) begin
					righting_done = 1'b1;
				end else if (e_w > c_side_w) begin
					top_panel_cmd  = CMD_CLOSED;
					side_panel_cmd = CMD_OPEN;
				end else if (e_w > c_top_w) begin
					top_panel_cmd  = CMD_OPEN;
					side_panel_cmd = CMD_CLOSED;
				end else if (e_w > c_w) begin
					top_panel_cmd  = CMD_CLOSED;
					side_panel_cmd = CMD_CLOSED;
				end
			end
		endcase
	end

endmodule

FILE: dv/tb_tilt_orientation_righting_sequencer_core.sv
// Self-checking testbench for the tilt orientation righting sequencer core.
module tb_tilt_orientation_righting_sequencer_core
	import tor_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_CYCLES = 4;
	localparam int STUCK_LIMIT = 3000;
	localparam int HOLD_CYCLES = 80;
	localparam int HOLD_PERIOD = 1500;
	localparam int PRINT_CAP = 200;
	localparam int PHASE_ITEMS = 255;
	localparam logic [1:0] REG_BEYOND = 2'd3;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        sample_valid = 1'b0;
	logic        sample_stall;
	sample_t     sample = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	result_t     result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	tilt_orientation_righting_sequencer_core DUT (.*);

	sample_t pending_q[$];
	result_t expected_q[$];

	// Mirror of the block's registers and orientation tracking.
	cfg_t cfg_mirror = '{tilt_threshold: TILT_THRESHOLD_RST, confirm_ms: CONFIRM_MS_RST,
		settle_ms: SETTLE_MS_RST};
	logic [2:0]  held_orient = ORIENT_UPRIGHT;
	logic [31:0] change_stamp = '0;

	int samples_queued = 0;
	int samples_taken = 0;
	int results_seen = 0;
	int mismatches = 0;
	int settings_used = 1;
	int send_idle_pct = 25;
	int recv_idle_pct = 88;
	int orient_seen[5] = '{default: 0};
	logic [31:0] clock_ms = '0;

	initial forever #5 clk = ~clk;

	function automatic result_t predict_result(sample_t smp);
		int y, z, t;
		logic y_level, z_level;
		logic [31:0] elapsed;
		longint unsigned e, c, s;
		result_t r;
		y = $signed(smp.accel_y);
		z = $signed(smp.accel_z);
		t = cfg_mirror.tilt_threshold;
		y_level = (y > -t) && (y < t);
		z_level = (z > -t) && (z < t);
		r = '0;
		if (z > t && y_level) r.orientation = ORIENT_UPRIGHT;
		else if (z < -t && y_level) r.orientation = ORIENT_UPSIDE_DOWN;
		else if (y > t && z_level) r.orientation = ORIENT_LEFT;
		else if (y < -t && z_level) r.orientation = ORIENT_RIGHT;
		else r.orientation = ORIENT_UNKNOWN;
		if (r.orientation != held_orient) change_stamp = smp.now_ms;
		held_orient = r.orientation;
		// Unsigned difference, so a stamp in the future reads as a long wait.
		elapsed = smp.now_ms - change_stamp;
		e = elapsed;
		c = cfg_mirror.confirm_ms;
		s = cfg_mirror.settle_ms;
		case (r.orientation)
			ORIENT_UPRIGHT: r.righting_done = (e > c);
			ORIENT_UPSIDE_DOWN: begin
				r.side_panel_cmd = CMD_CLOSED;
				if (e > s) r.top_panel_cmd = CMD_OPEN;
			end
			ORIENT_LEFT, ORIENT_RIGHT: begin
				if (e > c + s) begin
					r.top_panel_cmd = CMD_CLOSED;
					r.side_panel_cmd = CMD_OPEN;
				end else if (e > c) begin
					r.top_panel_cmd = CMD_CLOSED;
				end
			end
			default: begin
				if (e > c + BLIND_END_MS) begin
					r.righting_done = 1'b1;
				end else if (e > c + BLIND_OPEN_SIDE_MS) begin
					r.top_panel_cmd = CMD_CLOSED;
					r.side_panel_cmd = CMD_OPEN;
				end else if (e > c + BLIND_OPEN_TOP_MS) begin
					r.top_panel_cmd = CMD_OPEN;
					r.side_panel_cmd = CMD_CLOSED;
				end else if (e > c) begin
					r.top_panel_cmd = CMD_CLOSED;
					r.side_panel_cmd = CMD_CLOSED;
				end
			end
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		mismatches++;
		// Keep the log readable when the block is badly broken.
		if (mismatches <= PRINT_CAP)
			$display("%0t: %s mismatch, got %0d expected %0d", $time, what, got, want);
	endtask

	// Sample driver: presents the next pending word once the current one has moved.
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				expected_q.push_back(predict_result(sample));
				samples_taken++;
			end
			if (!(sample_valid && sample_stall)) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					sample <= pending_q.pop_front();
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// Result stall: random idling plus a periodic long hold-off so the block backs up.
	int stall_cycle = 0;
	int hold_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			stall_cycle++;
			if (stall_cycle % HOLD_PERIOD == HOLD_PERIOD / 2) hold_left = HOLD_CYCLES;
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Result monitor.
	result_t want;
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			results_seen++;
			if (result.orientation <= ORIENT_UNKNOWN) orient_seen[result.orientation]++;
			if (expected_q.size() == 0) begin
				report_mismatch("unexpected result word", result, 0);
			end else begin
				want = expected_q.pop_front();
				if (result.orientation != want.orientation)
					report_mismatch("orientation", result.orientation, want.orientation);
				if (result.top_panel_cmd != want.top_panel_cmd)
					report_mismatch("top_panel_cmd", result.top_panel_cmd, want.top_panel_cmd);
				if (result.side_panel_cmd != want.side_panel_cmd)
					report_mismatch("side_panel_cmd", result.side_panel_cmd,
						want.side_panel_cmd);
				if (result.righting_done != want.righting_done)
					report_mismatch("righting_done", result.righting_done, want.righting_done);
			end
		end
	end

	// Watchdog on cycles in which no word moves on either channel.
	int stuck_cycles = 0;
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("timeout after %0d cycles without progress", STUCK_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic add_sample(logic [31:0] now, logic [15:0] y, logic [15:0] z);
		sample_t smp;
		smp.now_ms = now;
		smp.accel_y = y;
		smp.accel_z = z;
		pending_q.push_back(smp);
		samples_queued++;
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_TILT_THRESHOLD: cfg_mirror.tilt_threshold = value[14:0];
			REG_CONFIRM_MS: cfg_mirror.confirm_ms = value[15:0];
			REG_SETTLE_MS: cfg_mirror.settle_ms = value[15:0];
			default: ;
		endcase
	endtask

	task automatic set_config(logic [31:0] thr, logic [31:0] confirm, logic [31:0] settle);
		write_reg(REG_TILT_THRESHOLD, thr);
		write_reg(REG_CONFIRM_MS, confirm);
		write_reg(REG_SETTLE_MS, settle);
		settings_used++;
	endtask

	task automatic drain();
		while (samples_taken != samples_queued || expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] gravity_count(int t, bit neg);
		int mag, top;
		top = neg ? 32768 : 32767;
		if (t >= top) mag = top;
		else case ($urandom_range(3))
			0: mag = t + 1;
			1: mag = top;
			default: mag = $urandom_range(top, t + 1);
		endcase
		return 16'(neg ? -mag : mag);
	endfunction

	function automatic logic [15:0] level_count(int t);
		int v;
		if (t == 0) return '0;
		case ($urandom_range(3))
			0: v = t - 1;
			1: v = 1 - t;
			2: v = 0;
			default: v = int'($urandom_range(2 * t - 2)) - (t - 1);
		endcase
		return 16'(v);
	endfunction

	// Mostly runs that hold one orientation while time advances across the
	// confirm, settle and blind phase bounds; the rest is raw noise.
	task automatic gen_phase(int n_items);
		int added, run_len, horizon, t;
		logic [2:0] cls;
		logic [15:0] y, z;
		t = cfg_mirror.tilt_threshold;
		horizon = cfg_mirror.confirm_ms + cfg_mirror.settle_ms + 12000;
		added = 0;
		while (added < n_items) begin
			run_len = $urandom_range(24, 3);
			if ($urandom_range(99) < 15) begin
				repeat (run_len) add_sample($urandom(), 16'($urandom()), 16'($urandom()));
			end else begin
				cls = 3'($urandom_range(ORIENT_UNKNOWN));
				if ($urandom_range(99) < 5) clock_ms += $urandom();
				repeat (run_len) begin
					clock_ms += $urandom_range(2 * horizon / run_len);
					case (cls)
						ORIENT_UPRIGHT: begin
							y = level_count(t);
							z = gravity_count(t, 1'b0);
						end
						ORIENT_UPSIDE_DOWN: begin
							y = level_count(t);
							z = gravity_count(t, 1'b1);
						end
						ORIENT_LEFT: begin
							y = gravity_count(t, 1'b0);
							z = level_count(t);
						end
						ORIENT_RIGHT: begin
							y = gravity_count(t, 1'b1);
							z = level_count(t);
						end
						default: case ($urandom_range(3))
							0: begin
								y = gravity_count(t, 1'($urandom_range(1)));
								z = gravity_count(t, 1'($urandom_range(1)));
							end
							1: begin
								y = level_count(t);
								z = 16'($urandom_range(1) ? t : -t);
							end
							2: begin
								y = 16'($urandom_range(1) ? t : -t);
								z = level_count(t);
							end
							default: begin
								y = 16'($urandom());
								z = 16'($urandom());
							end
						endcase
					endcase
					// An occasional glitch word breaks the run.
					if ($urandom_range(99) < 4)
						add_sample(clock_ms, 16'($urandom()), 16'($urandom()));
					else
						add_sample(clock_ms, y, z);
				end
			end
			added += run_len;
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at reset settings: reset state, each orientation and its
		// timed steps, strict threshold edges, time wrap and a stamp in the future.
		add_sample(32'd1000, 16'sd0, 16'sd701);
		add_sample(32'd1001, 16'sd0, 16'sd701);
		add_sample(32'd1002, 16'sd0, 16'sd700);
		add_sample(32'd2000, 16'sd699, -16'sd701);
		add_sample(32'd5000, -16'sd699, -16'sd32768);
		add_sample(32'd5001, 16'sd0, -16'sd701);
		add_sample(32'd6000, 16'sd701, 16'sd699);
		add_sample(32'd7001, 16'sd32767, -16'sd699);
		add_sample(32'd10001, 16'sd701, 16'sd0);
		add_sample(32'd10002, -16'sd701, 16'sd0);
		add_sample(32'd14003, -16'sd32768, 16'sd0);
		add_sample(32'd20000, 16'sd32767, 16'sd32767);
		add_sample(32'd21001, 16'sd32767, 16'sd32767);
		add_sample(32'd23001, 16'sd32767, 16'sd32767);
		add_sample(32'd27001, 16'sd32767, 16'sd32767);
		add_sample(32'd31001, 16'sd32767, 16'sd32767);
		add_sample(32'd31000, 16'sd32767, 16'sd32767);
		add_sample(32'hFFFF_FF00, 16'sd0, 16'sd32767);
		add_sample(32'h0000_0300, 16'sd0, 16'sd32767);
		add_sample(32'd5000, 16'sd701, 16'sd0);
		add_sample(32'd4999, 16'sd701, 16'sd0);
		add_sample(32'd100, -16'sd700, 16'sd32767);
		add_sample(32'hFFFF_FFFF, -16'sd701, -16'sd699);
		add_sample(32'd0, -16'sd32768, -16'sd32768);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase / 2)
				0: begin send_idle_pct = 25; recv_idle_pct = 88; end
				1: begin send_idle_pct = 88; recv_idle_pct = 25; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			case (phase)
				0: set_config(TILT_THRESHOLD_RST, CONFIRM_MS_RST, SETTLE_MS_RST);
				1: set_config(0, 0, 0);
				2: set_config(32767, 65535, 65535);
				3: begin
					// Upper bits beyond each register's width must be dropped,
					// and a write past the last register must change nothing.
					set_config({16'($urandom_range(65535)), 1'b0,
							15'($urandom_range(2000, 50))},
						{16'($urandom_range(65535)), 16'($urandom_range(3000))},
						{16'($urandom_range(65535)), 16'($urandom_range(5000))});
					write_reg(REG_BEYOND, $urandom());
				end
				4: set_config(1, 65535, 0);
				default: set_config(32766, 0, 65535);
			endcase
			gen_phase(PHASE_ITEMS);
			drain();
		end

		$display("Checked %0d result words over %0d register settings with three idle mixes.",
			results_seen, settings_used);
		$display("Orientations seen: upright %0d, upside down %0d, left %0d, right %0d, unknown %0d.",
			orient_seen[0], orient_seen[1], orient_seen[2], orient_seen[3], orient_seen[4]);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
